### rtl/gnms_pkg.sv
// Package for the greedy non-maximum suppression block: types, constants and codes.
package gnms_pkg;

  localparam int unsigned DefMaxRows     = 64;
  localparam int unsigned DefMaxCols     = 64;
  localparam int unsigned DefMaxSelected = 64;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_ROWS    = 3'd0,
    REG_FRAME_COLS    = 3'd1,
    REG_MAX_POINTS    = 3'd2,
    REG_WINDOW_RADIUS = 3'd3,
    REG_COORD_OFFSET  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] response;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic               found;
    logic [6:0]         point_row;
    logic [6:0]         point_col;
    logic signed [31:0] point_response;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [6:0] frame_rows;
    logic [6:0] frame_cols;
    logic [6:0] max_points;
    logic [3:0] window_radius;
    logic [4:0] coord_offset;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_START,
    ST_SCAN,
    ST_EMIT,
    ST_MARK,
    ST_DONE
  } state_e;

endpackage

### rtl/greedy_non_maxima_suppression.sv
// Top level of the greedy non-maximum suppression corner selector.
// Pixels are taken one per beat while the frame loads. After the frame-end beat the block
// stalls its input: it clears the mask over the frame, then for each point starts a search,
// scans the frame with one shared signed compare fed by the registered memory reads, takes
// the point and marks its clipped window one mask bit per cycle. Unless the point limit or
// an empty frame ends the search, one more start and scan follow and find it empty, and the
// last result is then sent. A taken point waits while the previous result is stalled on
// the output. The selection time is set by the single read port of the response and mask
// memories.
module greedy_non_maxima_suppression
  import gnms_pkg::*;
#(
  parameter int unsigned MaxRows     = DefMaxRows,
  parameter int unsigned MaxCols     = DefMaxCols,
  parameter int unsigned MaxSelected = DefMaxSelected
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  pixel_t              in_data_i,
  output logic                out_valid,
  input  logic                out_stall,
  output point_t              out_data_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned RW    = $clog2(MaxRows + 1);
  localparam int unsigned CLW   = $clog2(MaxCols + 1);
  localparam int unsigned SW    = $clog2(MaxSelected + 1);

  cfg_t cfg;
  assign cfg_ready = 1'b1;

  gnms_cfg u_cfg (
    .clk_i, .rst_ni, .we_i(cfg_valid), .idx_i(cfg_idx_i), .data_i(cfg_data_i), .cfg_o(cfg)
  );

  // Saturated frame geometry.
  logic [RW-1:0]  rows;
  logic [CLW-1:0] cols;
  logic [SW-1:0]  limit;
  always_comb begin
    rows  = (32'(cfg.frame_rows) > MaxRows) ? RW'(MaxRows) : RW'(cfg.frame_rows);
    cols  = (32'(cfg.frame_cols) > MaxCols) ? CLW'(MaxCols) : CLW'(cfg.frame_cols);
    limit = (32'(cfg.max_points) > MaxSelected) ? SW'(MaxSelected) : SW'(cfg.max_points);
  end

  state_e state_q, state_d;
  logic [CW-1:0]  pix_cnt_q, pix_cnt_d;
  logic [CW-1:0]  idx_q, idx_d;       // scan / clear address
  logic [RW-1:0]  srow_q, srow_d;     // row, column of the scan address
  logic [CLW-1:0] scol_q, scol_d;
  logic           pvld_q, pvld_d;     // a read is in flight for the previous address
  logic [RW-1:0]  prow_q, prow_d;     // row, column of the previous scan address
  logic [CLW-1:0] pcol_q, pcol_d;
  logic           have_q, have_d;
  logic [RW-1:0]  brow_q, brow_d;
  logic [CLW-1:0] bcol_q, bcol_d;
  logic signed [31:0] bresp_q, bresp_d;
  logic [SW-1:0]  sel_q, sel_d;
  logic signed [5:0] dr_q, dr_d, dc_q, dc_d;
  logic           ov_q, ov_d;
  point_t         out_q, out_d;
  logic           pend_q, pend_d;     // a taken point held until we know whether it is the last
  point_t         pend_pt_q, pend_pt_d;

  logic [CW-1:0] total;
  assign total = CW'(32'(rows) * 32'(cols));

  // Memories.
  logic          r_we;
  logic [AW-1:0] rd_addr;
  logic [31:0]   r_rdata;
  logic          m_we, m_wdata;
  logic [AW-1:0] m_waddr;
  logic          m_rdata;

  assign rd_addr = idx_q[AW-1:0];

  gnms_ram #(.Width(32), .Depth(Depth)) u_resp (
    .clk_i, .we_i(r_we), .waddr_i(pix_cnt_q[AW-1:0]), .wdata_i(in_data_i.response),
    .raddr_i(rd_addr), .rdata_o(r_rdata)
  );
  gnms_ram #(.Width(1), .Depth(Depth)) u_mask (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(rd_addr), .rdata_o(m_rdata)
  );

  // Window position under marking.
  logic signed [11:0] mr, mc;
  logic               m_in;
  logic [AW-1:0]      m_addr;
  always_comb begin
    mr     = $signed({1'b0, 11'(brow_q)}) + 12'(dr_q);
    mc     = $signed({1'b0, 11'(bcol_q)}) + 12'(dc_q);
    m_in   = (mr >= 0) && (mr < $signed({1'b0, 11'(rows)})) &&
             (mc >= 0) && (mc < $signed({1'b0, 11'(cols)}));
    m_addr = AW'(32'(mr[10:0]) * 32'(cols) + 32'(mc[10:0]));
  end

  logic signed [5:0] rad;
  assign rad = $signed({2'b00, cfg.window_radius});
  logic [7:0] off;
  assign off = 8'd1 + 8'(cfg.coord_offset);

  logic out_free, scan_more, mark_end, take;
  assign out_free  = !ov_q || !out_stall;
  assign scan_more = (idx_q < total);
  assign mark_end  = (dr_q == rad) && (dc_q == rad);
  // Candidate from registered memory data (previous scan address); ties keep the earlier one.
  assign take      = pvld_q && !m_rdata && (!have_q || $signed(r_rdata) > bresp_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_valid && in_data_i.frame_end) state_d = ST_CLEAR;
      ST_CLEAR: if (!scan_more) state_d = ST_START;
      ST_START: state_d = (sel_q >= limit || total == '0) ? ST_DONE : ST_SCAN;
      ST_SCAN:  if (!scan_more && !pvld_q) state_d = ST_EMIT;
      ST_EMIT: begin
        if (!have_q) begin
          state_d = ST_DONE;
        end else if (!pend_q || out_free) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK:  if (mark_end) state_d = ST_START;
      ST_DONE:  if (out_free) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pix_cnt_d = pix_cnt_q; idx_d = idx_q; srow_d = srow_q; scol_d = scol_q;
    pvld_d = pvld_q; prow_d = prow_q; pcol_d = pcol_q; have_d = have_q;
    brow_d = brow_q; bcol_d = bcol_q; bresp_d = bresp_q; sel_d = sel_q;
    dr_d = dr_q; dc_d = dc_q; out_d = out_q; pend_d = pend_q; pend_pt_d = pend_pt_q;
    ov_d = ov_q && out_stall;
    r_we = 1'b0; m_we = 1'b0; m_waddr = idx_q[AW-1:0]; m_wdata = 1'b0;
    in_stall = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (pix_cnt_q < CW'(Depth)) begin
            r_we = 1'b1;
            pix_cnt_d = pix_cnt_q + 1'b1;
          end
          if (in_data_i.frame_end) begin
            pix_cnt_d = '0; idx_d = '0; sel_d = '0; pend_d = 1'b0;
          end
        end
      end
      ST_CLEAR: begin
        if (scan_more) begin
          m_we = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      ST_START: begin
        idx_d = '0; srow_d = '0; scol_d = '0; pvld_d = 1'b0; have_d = 1'b0;
      end
      ST_SCAN: begin
        if (take) begin
          have_d = 1'b1; bresp_d = $signed(r_rdata);
          brow_d = prow_q; bcol_d = pcol_q;
        end
        pvld_d = scan_more;
        if (scan_more) begin
          prow_d = srow_q; pcol_d = scol_q;
          idx_d = idx_q + 1'b1;
          if (scol_q == cols - 1'b1) begin
            scol_d = '0; srow_d = srow_q + 1'b1;
          end else begin
            scol_d = scol_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (have_q && (!pend_q || out_free)) begin
          // Send the earlier point, which is not the last; hold the new one.
          if (pend_q) begin
            out_d = pend_pt_q; ov_d = 1'b1;
          end
          pend_d = 1'b1;
          pend_pt_d.found = 1'b1;
          pend_pt_d.point_row = 7'(8'(brow_q) + off);
          pend_pt_d.point_col = 7'(8'(bcol_q) + off);
          pend_pt_d.point_response = bresp_q;
          pend_pt_d.last_point = 1'b0;
          sel_d = sel_q + 1'b1;
          dr_d = -rad; dc_d = -rad;
        end
      end
      ST_MARK: begin
        m_we = m_in; m_waddr = m_addr; m_wdata = 1'b1;
        if (dc_q == rad) begin
          dc_d = -rad; dr_d = dr_q + 6'sd1;
        end else begin
          dc_d = dc_q + 6'sd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d = pend_q ? pend_pt_q : '0;
          out_d.last_point = 1'b1; ov_d = 1'b1; pend_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pix_cnt_q <= '0;
      sel_q <= '0;
      ov_q <= 1'b0;
      pend_q <= 1'b0;
      have_q <= 1'b0;
      pvld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pix_cnt_q <= pix_cnt_d;
      sel_q <= sel_d;
      ov_q <= ov_d;
      pend_q <= pend_d;
      have_q <= have_d;
      pvld_q <= pvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; srow_q <= srow_d; scol_q <= scol_d;
    prow_q <= prow_d; pcol_q <= pcol_d;
    brow_q <= brow_d; bcol_q <= bcol_d; bresp_q <= bresp_d;
    dr_q <= dr_d; dc_q <= dc_d; out_q <= out_d; pend_pt_q <= pend_pt_d;
  end

  assign out_valid  = ov_q;
  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> in_stall) else $error("input taken while selecting");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data_o)))
    else $error("stalled result changed");
  a_sel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(sel_q) <= MaxSelected)) else $error("selected count overran");
`endif

endmodule

### rtl/gnms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gnms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/gnms_cfg.sv
// Configuration register file for the suppression block.
module gnms_cfg
  import gnms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_rows    <= 7'd64;
      cfg_q.frame_cols    <= 7'd64;
      cfg_q.max_points    <= 7'd64;
      cfg_q.window_radius <= 4'd1;
      cfg_q.coord_offset  <= 5'd0;
    end else if (we_i) begin
      unique case (idx_i)
        REG_FRAME_ROWS:    cfg_q.frame_rows    <= data_i;
        REG_FRAME_COLS:    cfg_q.frame_cols    <= data_i;
        REG_MAX_POINTS:    cfg_q.max_points    <= data_i;
        REG_WINDOW_RADIUS: cfg_q.window_radius <= data_i[3:0];
        REG_COORD_OFFSET:  cfg_q.coord_offset  <= data_i[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
